// ----- src/dlse_pkg.sv -----
// ---------------------------------------------------------------------------
// dlse_pkg
// Shared types and constants for the DCT coefficient LSB hidden-bit engine.
// ---------------------------------------------------------------------------
`default_nettype none

package dlse_pkg;

	localparam int COEF_BITS_DEF  = 12;
	localparam int COUNT_BITS_DEF = 24;

	localparam int THR_W   = 12;
	localparam int START_W = 20;
	localparam int LEN_W   = 21;
	localparam int SKIP_W  = START_W + 3;
	localparam int BITS_W  = LEN_W + 3;
	localparam int CAP_W   = 21;
	localparam int CFG_W   = 21;
	localparam int CFG_IDX_W = 2;

	localparam logic [CAP_W-1:0] CAP_MAX = {CAP_W{1'b1}};

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MODE         = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_BYTE   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH_BYTES = 2'd3;

	typedef struct packed {
		logic signed [THR_W-1:0] threshold;
		logic                    mode;
		logic [START_W-1:0]      start_byte;
		logic [LEN_W-1:0]        length_bytes;
	} cfg_t;

	typedef struct packed {
		logic             bit_taken;
		logic [7:0]       data_byte;
		logic             byte_valid;
		logic             pass_end;
		logic             status;
		logic [CAP_W-1:0] capacity_bytes;
	} res_flags_t;

endpackage : dlse_pkg

`default_nettype wire

// ----- src/dlse_core.sv -----
// ---------------------------------------------------------------------------
// dlse_core
// Pass state (skip, bit and eligible counters, byte accumulator) and the
// per-coefficient decision: eligibility, LSB replace or LSB collect.
// ---------------------------------------------------------------------------
`default_nettype none

module dlse_core import dlse_pkg::*; #(
	parameter int COEF_BITS  = COEF_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire cfg_t                        cfg,
	input  wire logic signed [COEF_BITS-1:0] coeff,
	input  wire logic                        payload_bit,
	input  wire logic                        first,
	input  wire logic                        last,
	output logic signed [COEF_BITS-1:0]      coeff_out,
	output res_flags_t                       res
);

	localparam int CMP_W = (COEF_BITS > THR_W) ? COEF_BITS : THR_W;

	logic [SKIP_W-1:0]     skip_q,  skip_cur,  skip_nxt;
	logic [BITS_W-1:0]     bits_q,  bits_cur,  bits_nxt, total;
	logic [7:0]            acc_q,   acc_cur,   acc_nxt,  acc_or;
	logic [COUNT_BITS-1:0] cnt_q,   cnt_cur,   cnt_nxt;
	logic signed [CMP_W-1:0] coeff_x, thr_x;
	logic                  elig, touch, span_ok;
	logic [2:0]            pos;
	logic [31:0]           cnt_w, cap_w;

	always_comb begin
		skip_cur = first ? {cfg.start_byte, 3'b000} : skip_q;
		bits_cur = first ? '0 : bits_q;
		acc_cur  = first ? '0 : acc_q;
		cnt_cur  = first ? '0 : cnt_q;
		total    = {cfg.length_bytes, 3'b000};

		coeff_x = CMP_W'(coeff);
		thr_x   = CMP_W'(cfg.threshold);
		elig    = coeff_x > thr_x;

		cnt_nxt  = (elig && (cnt_cur != '1)) ? cnt_cur + 1'b1 : cnt_cur;
		skip_nxt = (elig && (skip_cur != '0)) ? skip_cur - 1'b1 : skip_cur;
		touch    = elig && (skip_cur == '0) && (bits_cur < total);
		bits_nxt = touch ? bits_cur + 1'b1 : bits_cur;
		pos      = bits_cur[2:0];

		coeff_out = coeff;
		res       = '0;
		acc_or    = acc_cur | (8'(coeff[0]) << pos);
		acc_nxt   = acc_cur;
		if (touch) begin
			if (cfg.mode) begin
				coeff_out     = {coeff[COEF_BITS-1:1], payload_bit};
				res.bit_taken = 1'b1;
			end else if (pos == 3'd7) begin
				res.data_byte  = acc_or;
				res.byte_valid = 1'b1;
				acc_nxt        = '0;
			end else begin
				acc_nxt = acc_or;
			end
		end

		span_ok = (skip_nxt == '0) && (bits_nxt >= total);
		cnt_w   = 32'(cnt_nxt);
		cap_w   = cnt_w >> 3;
		res.pass_end = last;
		if (last) begin
			res.status         = !span_ok;
			res.capacity_bytes = (cap_w > 32'(CAP_MAX)) ? CAP_MAX : cap_w[CAP_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= '0;
			bits_q <= '0;
			acc_q  <= '0;
			cnt_q  <= '0;
		end else if (en) begin
			skip_q <= skip_nxt;
			bits_q <= bits_nxt;
			acc_q  <= acc_nxt;
			cnt_q  <= cnt_nxt;
		end
	end

endmodule : dlse_core

`default_nettype wire

// ----- src/dct_lsb_stego_embed_extract_top.sv -----
// ---------------------------------------------------------------------------
// dct_lsb_stego_embed_extract_top
// Hidden-bit embed/extract engine over a stream of quantized DCT coefficients.
//
// Input channel (in_valid/in_ready) takes one word per coefficient with its
// payload bit and first/last pass marks. Output channel (out_valid/out_ready)
// returns one word per coefficient: the coefficient (LSB replaced in embed
// mode), bit_taken, extracted byte with byte_valid, and at the last word of a
// pass the capacity in bytes and the fit status.
// The input register holds an accepted word; its result is loaded into the
// output register when the word advances.
// Throughput: one word per cycle while the output is not stalled; the only
// loop is the counter/accumulator update, registered in dlse_core.
// Stall: while out_valid is high and out_ready is low the output holds,
// the input register keeps its word and in_ready drops once it is occupied.
// Reset clears all counters and loads threshold 1, extract mode, start
// byte 0 and length 1. Configuration writes (cfg_we) must be made only
// while no word is in flight; the block itself does not enforce this.
// ---------------------------------------------------------------------------
`default_nettype none

module dct_lsb_stego_embed_extract_top import dlse_pkg::*; #(
	parameter int COEF_BITS  = COEF_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [CFG_IDX_W-1:0]        cfg_idx,
	input  wire logic [CFG_W-1:0]            cfg_wdata,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic signed [COEF_BITS-1:0] coeff,
	input  wire logic                        payload_bit,
	input  wire logic                        first,
	input  wire logic                        last,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic signed [COEF_BITS-1:0]      coeff_out,
	output logic                             bit_taken,
	output logic [7:0]                       data_byte,
	output logic                             byte_valid,
	output logic                             pass_end,
	output logic                             status,
	output logic [CAP_W-1:0]                 capacity_bytes
);

	cfg_t cfg_q;

	logic                        valid_s1;
	logic signed [COEF_BITS-1:0] coeff_s1;
	logic                        pbit_s1, first_s1, last_s1;
	logic                        advance;
	logic signed [COEF_BITS-1:0] core_coeff;
	res_flags_t                  core_res, res_q;
	logic signed [COEF_BITS-1:0] coeff_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold    <= 12'sd1;
			cfg_q.mode         <= 1'b0;
			cfg_q.start_byte   <= '0;
			cfg_q.length_bytes <= LEN_W'(1);
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_THRESHOLD:    cfg_q.threshold    <= cfg_wdata[THR_W-1:0];
				REG_MODE:         cfg_q.mode         <= cfg_wdata[0];
				REG_START_BYTE:   cfg_q.start_byte   <= cfg_wdata[START_W-1:0];
				REG_LENGTH_BYTES: cfg_q.length_bytes <= cfg_wdata[LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			coeff_s1 <= coeff;
			pbit_s1  <= payload_bit;
			first_s1 <= first;
			last_s1  <= last;
		end
	end

	dlse_core #(
		.COEF_BITS  (COEF_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (advance),
		.cfg         (cfg_q),
		.coeff       (coeff_s1),
		.payload_bit (pbit_s1),
		.first       (first_s1),
		.last        (last_s1),
		.coeff_out   (core_coeff),
		.res         (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || out_ready) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			coeff_q <= core_coeff;
			res_q   <= core_res;
		end
	end

	assign coeff_out      = coeff_q;
	assign bit_taken      = res_q.bit_taken;
	assign data_byte      = res_q.data_byte;
	assign byte_valid     = res_q.byte_valid;
	assign pass_end       = res_q.pass_end;
	assign status         = res_q.status;
	assign capacity_bytes = res_q.capacity_bytes;

endmodule : dct_lsb_stego_embed_extract_top

`default_nettype wire
